>>> rtl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while reset is asserted.
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Clocked next-cycle implication check.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/fjot_pkg.sv
// Types and constants of the flat JSON object tokenizer.
`default_nettype none
package fjot_pkg;
	localparam int QDepth = 4;
	localparam int QAw = 2;

	typedef enum logic [3:0] {
		LM_IDLE   = 4'b0001,
		LM_STRING = 4'b0010,
		LM_NUMBER = 4'b0100,
		LM_NULL   = 4'b1000
	} lex_t;

	typedef enum logic [6:0] {
		PH_BRACE = 7'b0000001,
		PH_KEY   = 7'b0000010,
		PH_COLON = 7'b0000100,
		PH_VALUE = 7'b0001000,
		PH_COMMA = 7'b0010000,
		PH_DONE  = 7'b0100000,
		PH_FAIL  = 7'b1000000
	} phase_t;

	typedef enum logic [3:0] {
		TK_LBRACE, TK_RBRACE, TK_LBRACKET, TK_RBRACKET, TK_COLON, TK_COMMA,
		TK_STRING, TK_NUMBER, TK_NULL
	} tok_t;

	localparam logic [2:0] EV_KEY_CHAR = 3'd0;
	localparam logic [2:0] EV_KEY_END  = 3'd1;
	localparam logic [2:0] EV_STR_CHAR = 3'd2;
	localparam logic [2:0] EV_STR_END  = 3'd3;
	localparam logic [2:0] EV_INT      = 3'd4;
	localparam logic [2:0] EV_NULL     = 3'd5;
	localparam logic [2:0] EV_OBJ_END  = 3'd6;
	localparam logic [2:0] EV_ERROR    = 3'd7;

	localparam logic [3:0] ERR_TOKENS    = 4'd0;
	localparam logic [3:0] ERR_LENGTH    = 4'd1;
	localparam logic [3:0] ERR_BAD_CHAR  = 4'd2;
	localparam logic [3:0] ERR_NO_BRACE  = 4'd3;
	localparam logic [3:0] ERR_NO_KEY    = 4'd4;
	localparam logic [3:0] ERR_NO_COLON  = 4'd5;
	localparam logic [3:0] ERR_BAD_VALUE = 4'd6;
	localparam logic [3:0] ERR_NO_COMMA  = 4'd7;
	localparam logic [3:0] ERR_EARLY_END = 4'd8;

	localparam logic [0:0] REG_MAX_TOKENS = 1'b0;
	localparam logic [0:0] REG_MAX_LENGTH = 1'b1;

	localparam logic [7:0] TOKENS_RESET = 8'd50;
	localparam logic [9:0] LENGTH_RESET = 10'd256;

	localparam logic [7:0] CH_END   = 8'h2A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_L     = 8'h6C;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [31:0] val;
		logic [3:0]  err;
		logic        last;
	} res_t;

	// Results of one byte, handed from front to queue
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} rpair_t;

	function automatic res_t mk_res(logic [2:0] kind, logic [7:0] ch, logic [31:0] val,
			logic [3:0] err);
		res_t r;
		r.kind = kind;
		r.ch   = ch;
		r.val  = val;
		r.err  = err;
		r.last = 1'b0;
		return r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/fjot_front.sv
// Front end: lexer and flat-object parser, one byte per cycle while take is high.
`default_nettype none
`include "assert_macros.svh"
module fjot_front import fjot_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] max_tokens,
	input  wire logic [9:0] max_input_length,
	output rpair_t          res
);
	typedef struct packed {
		phase_t ph;
		logic   inc;
		logic   emit;
		res_t   r;
	} fin_t;

	lex_t                   lex_q, lex_d;
	phase_t                 ph_q, ph_d;
	logic [1:0]             nul_q, nul_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;
	logic                   neg_q, neg_d;
	logic                   frz_q, frz_d;
	logic [9:0]             bc_q, bc_d;
	logic [7:0]             tc_q, tc_d;

	// Parser step for one completed token
	function automatic fin_t finish(tok_t tok, phase_t ph, logic [7:0] tc, logic [7:0] mt,
			logic [31:0] nv);
		fin_t f;
		f.ph   = ph;
		f.inc  = 1'b0;
		f.emit = 1'b0;
		f.r    = '0;
		if (tc >= mt) begin
			f.ph = PH_FAIL; f.emit = 1'b1; f.r = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_TOKENS);
		end else begin
			f.inc = 1'b1;
			case (ph)
				PH_BRACE: begin
					if (tok == TK_LBRACE) f.ph = PH_KEY;
					else begin
						f.ph = PH_FAIL; f.emit = 1'b1;
						f.r = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_NO_BRACE);
					end
				end
				PH_KEY: begin
					f.emit = 1'b1;
					if (tok == TK_STRING) begin
						f.ph = PH_COLON; f.r = mk_res(EV_KEY_END, 8'd0, 32'd0, 4'd0);
					end else if (tok == TK_RBRACE) begin
						f.ph = PH_DONE; f.r = mk_res(EV_OBJ_END, 8'd0, 32'd0, 4'd0);
					end else begin
						f.ph = PH_FAIL; f.r = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_NO_KEY);
					end
				end
				PH_COLON: begin
					if (tok == TK_COLON) f.ph = PH_VALUE;
					else begin
						f.ph = PH_FAIL; f.emit = 1'b1;
						f.r = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_NO_COLON);
					end
				end
				PH_VALUE: begin
					f.emit = 1'b1;
					f.ph = PH_COMMA;
					if (tok == TK_STRING) f.r = mk_res(EV_STR_END, 8'd0, 32'd0, 4'd0);
					else if (tok == TK_NUMBER) f.r = mk_res(EV_INT, 8'd0, nv, 4'd0);
					else if (tok == TK_NULL) f.r = mk_res(EV_NULL, 8'd0, 32'd0, 4'd0);
					else begin
						f.ph = PH_FAIL; f.r = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_BAD_VALUE);
					end
				end
				PH_COMMA: begin
					if (tok == TK_COMMA) f.ph = PH_KEY;
					else if (tok == TK_RBRACE) begin
						f.ph = PH_DONE; f.emit = 1'b1;
						f.r = mk_res(EV_OBJ_END, 8'd0, 32'd0, 4'd0);
					end else begin
						f.ph = PH_FAIL; f.emit = 1'b1;
						f.r = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_NO_COMMA);
					end
				end
				default: ;
			endcase
		end
		return f;
	endfunction

	// Signed value of the pending number, low 32 bits
	logic signed [VALUE_WIDTH-1:0] nsig;
	logic [63:0]                   next64;
	logic [31:0]                   nval;
	always_comb begin
		nsig   = neg_q ? -acc_q : acc_q;
		next64 = 64'(nsig);
		nval   = next64[31:0];
	end

	// Byte classification
	logic [7:0] c;
	logic       is_term, is_digit;
	logic [3:0] digit;
	assign c        = data_byte;
	assign is_term  = (c == CH_END) || (c == 8'd0);
	assign is_digit = (c >= 8'h30) && (c <= 8'h39);
	assign digit    = c[3:0];

	// Next state and results of the accepted byte
	always_comb begin
		fin_t   f;
		res_t   rv [2];
		logic [1:0] n;
		logic   do_idle;
		logic   ftok;
		tok_t   tok;
		lex_d = lex_q; ph_d = ph_q; nul_d = nul_q; acc_d = acc_q;
		neg_d = neg_q; frz_d = frz_q; bc_d = bc_q; tc_d = tc_q;
		rv[0] = '0; rv[1] = '0; n = 2'd0;
		do_idle = 1'b0; ftok = 1'b0; tok = TK_LBRACE; f = '0;
		if (take) begin
			if (is_term) begin
				if (ph_q != PH_FAIL) begin
					if (lex_q == LM_NUMBER || lex_q == LM_STRING) begin
						f = finish((lex_q == LM_NUMBER) ? TK_NUMBER : TK_STRING,
							ph_d, tc_d, max_tokens, nval);
						ph_d = f.ph;
						if (f.emit) begin rv[n[0]] = f.r; n = n + 2'd1; end
					end else if (lex_q == LM_NULL) begin
						ph_d = PH_FAIL;
						rv[n[0]] = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_BAD_CHAR);
						n = n + 2'd1;
					end
					if (ph_d != PH_FAIL && ph_d != PH_DONE) begin
						rv[n[0]] = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_EARLY_END);
						n = n + 2'd1;
					end
				end
				lex_d = LM_IDLE; nul_d = 2'd0; ph_d = PH_BRACE; acc_d = '0;
				neg_d = 1'b0; frz_d = 1'b0; bc_d = '0; tc_d = '0;
			end else if (ph_q == PH_FAIL) begin
				// swallow bytes until the terminator
			end else if (bc_q >= max_input_length) begin
				ph_d = PH_FAIL; lex_d = LM_IDLE; nul_d = 2'd0;
				rv[0] = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_LENGTH); n = 2'd1;
			end else begin
				bc_d = bc_q + 10'd1;
				case (lex_q)
					LM_STRING: begin
						if (c == CH_QUOTE) begin
							lex_d = LM_IDLE; ftok = 1'b1; tok = TK_STRING;
						end else if (ph_q == PH_KEY) begin
							rv[0] = mk_res(EV_KEY_CHAR, c, 32'd0, 4'd0); n = 2'd1;
						end else if (ph_q == PH_VALUE) begin
							rv[0] = mk_res(EV_STR_CHAR, c, 32'd0, 4'd0); n = 2'd1;
						end
					end
					LM_NULL: begin
						if ((nul_q == 2'd1 && c == CH_U) || (nul_q != 2'd1 && c == CH_L)) begin
							if (nul_q == 2'd3) begin
								nul_d = 2'd0; lex_d = LM_IDLE; ftok = 1'b1; tok = TK_NULL;
							end else nul_d = nul_q + 2'd1;
						end else begin
							ph_d = PH_FAIL; lex_d = LM_IDLE; nul_d = 2'd0;
							rv[0] = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_BAD_CHAR); n = 2'd1;
						end
					end
					LM_NUMBER: begin
						if (is_digit) begin
							if (!frz_q)
								acc_d = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(digit);
						end else if (c == CH_DOT) begin
							frz_d = 1'b1;
						end else begin
							lex_d = LM_IDLE;
							f = finish(TK_NUMBER, ph_d, tc_d, max_tokens, nval);
							ph_d = f.ph;
							tc_d = tc_d + {7'd0, f.inc};
							if (f.emit) begin rv[n[0]] = f.r; n = n + 2'd1; end
							if (ph_d == PH_FAIL) nul_d = 2'd0;
							else do_idle = 1'b1;
						end
					end
					default: do_idle = 1'b1;
				endcase
				// Idle lexer: start a token or complete a single-byte one
				if (do_idle) begin
					case (c)
						8'h7B: begin ftok = 1'b1; tok = TK_LBRACE; end
						8'h7D: begin ftok = 1'b1; tok = TK_RBRACE; end
						8'h5B: begin ftok = 1'b1; tok = TK_LBRACKET; end
						8'h5D: begin ftok = 1'b1; tok = TK_RBRACKET; end
						8'h3A: begin ftok = 1'b1; tok = TK_COLON; end
						8'h2C: begin ftok = 1'b1; tok = TK_COMMA; end
						CH_QUOTE: lex_d = LM_STRING;
						8'h20, 8'h09, 8'h0A, 8'h0D: ;
						CH_MINUS: begin
							lex_d = LM_NUMBER; acc_d = '0; neg_d = 1'b1; frz_d = 1'b0;
						end
						CH_N: begin lex_d = LM_NULL; nul_d = 2'd1; end
						default: begin
							if (is_digit) begin
								lex_d = LM_NUMBER; acc_d = VALUE_WIDTH'(digit);
								neg_d = 1'b0; frz_d = 1'b0;
							end else begin
								ph_d = PH_FAIL; lex_d = LM_IDLE; nul_d = 2'd0;
								rv[n[0]] = mk_res(EV_ERROR, 8'd0, 32'd0, ERR_BAD_CHAR);
								n = n + 2'd1;
							end
						end
					endcase
				end
				// Token completed by this byte
				if (ftok) begin
					f = finish(tok, ph_d, tc_d, max_tokens, nval);
					ph_d = f.ph;
					tc_d = tc_d + {7'd0, f.inc};
					if (f.emit) begin rv[n[0]] = f.r; n = n + 2'd1; end
					if (ph_d == PH_FAIL) begin lex_d = LM_IDLE; nul_d = 2'd0; end
				end
			end
		end
		if (n == 2'd1) rv[0].last = 1'b1;
		if (n == 2'd2) rv[1].last = 1'b1;
		res.n  = n;
		res.r0 = rv[0];
		res.r1 = rv[1];
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q <= LM_IDLE; ph_q <= PH_BRACE; nul_q <= 2'd0; acc_q <= '0;
			neg_q <= 1'b0; frz_q <= 1'b0; bc_q <= '0; tc_q <= '0;
		end else begin
			lex_q <= lex_d; ph_q <= ph_d; nul_q <= nul_d; acc_q <= acc_d;
			neg_q <= neg_d; frz_q <= frz_d; bc_q <= bc_d; tc_q <= tc_d;
		end
	end

	`CHK_NEXT(a_term_rearms, take && is_term, ph_q == PH_BRACE && bc_q == 10'd0, "no rearm")
	`CHK_IMPL(a_fail_silent, take && !is_term && ph_q == PH_FAIL, res.n == 2'd0, "output in fail")
	`CHK_IMPL(a_last_marked, res.n != 2'd0, (res.n == 2'd1) ? res.r0.last : res.r1.last,
		"last flag missing")
endmodule
`default_nettype wire

>>> rtl/fjot_queue.sv
// Back end: result queue taking up to two words per cycle, one out.
`default_nettype none
`include "assert_macros.svh"
module fjot_queue import fjot_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  rpair_t    wr,
	output logic      full,
	output logic      empty,
	input  wire logic pop,
	output res_t      head
);
	res_t            mem_q [QDepth];
	logic [QAw-1:0]  wp_q, rp_q;
	logic [QAw:0]    cnt_q;
	logic            do_pop;

	// Room for a worst-case pair is kept free
	assign full   = (cnt_q > 3'(QDepth - 2));
	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign head   = mem_q[rp_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) mem_q[wp_q] <= wr.r0;
		if (wr.n == 2'd2) mem_q[wp_q + QAw'(1)] <= wr.r1;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QAw'(wr.n);
			rp_q  <= rp_q + QAw'(do_pop);
			cnt_q <= cnt_q + (QAw+1)'(wr.n) - (QAw+1)'(do_pop);
		end
	end

	`CHK_IMPL(a_no_overflow, 1'b1, cnt_q <= 3'(QDepth), "queue overflow")
	`CHK_IMPL(a_no_write_full, full, wr.n == 2'd0, "write while full")
	`CHK_IMPL(a_pair_room, !full, cnt_q <= 3'(QDepth - 2), "no room for a pair")
endmodule
`default_nettype wire

>>> rtl/flat_json_object_tokenizer.sv
// Top level of the flat JSON object tokenizer.
// A byte's results are written into the queue when the byte is taken and reach
// the outputs in queue order. Bytes are taken one per cycle while full is low;
// full is set once three of the 4 entries are held; two-result bytes need two pops.
// Reset (arst_n low, asynchronous) clears parser state and the queue and loads
// max_tokens with 50 and max_input_length with 256; no clearing pass is needed.
`default_nettype none
module flat_json_object_tokenizer import fjot_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       event_kind,
	output logic [7:0]       char_byte,
	output logic signed [31:0] int_value,
	output logic [3:0]       error_code,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);
	logic [7:0] max_tokens_q;
	logic [9:0] max_len_q;
	rpair_t     pair;
	res_t       head;
	logic       take;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= TOKENS_RESET;
			max_len_q    <= LENGTH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_TOKENS: max_tokens_q <= cfg_data[7:0];
				REG_MAX_LENGTH: max_len_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	fjot_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk, .arst_n, .take, .data_byte,
		.max_tokens(max_tokens_q), .max_input_length(max_len_q), .res(pair)
	);

	fjot_queue u_queue (
		.clk, .arst_n, .wr(pair), .full, .empty, .pop, .head
	);

	assign event_kind = head.kind;
	assign char_byte  = head.ch;
	assign int_value  = head.val;
	assign error_code = head.err;
	assign last       = head.last;
endmodule
`default_nettype wire
